[src/cscan_pkg.sv]
// Shared types and constants for the C-SCAN disk scheduler.
package cscan_pkg;

	localparam int unsigned CYL_W  = 16;
	localparam int unsigned SEEK_W = 18;
	localparam int unsigned RCNT_W = 16;
	localparam logic [SEEK_W-1:0] SEEK_MAX  = '1;
	localparam logic [RCNT_W-1:0] RCNT_MAX  = '1;
	localparam logic [CYL_W-1:0]  MAXCYL_RST = '1;

	// register indexes on the APB port
	typedef enum logic {
		REG_START_HEAD   = 1'b0,
		REG_MAX_CYLINDER = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_REQUEST = 2'd1,
		KIND_SWEEP   = 2'd2,
		KIND_WRAP    = 2'd3
	} stop_kind_t;

	typedef struct packed {
		logic [CYL_W-1:0] cylinder;
		logic             batch_end;
	} req_t;

	typedef struct packed {
		logic [CYL_W-1:0]  stop_cylinder;
		stop_kind_t        stop_kind;
		logic [SEEK_W-1:0] seek_total;
		logic [RCNT_W-1:0] request_count;
		logic              overflowed;
		logic              run_last;
	} stop_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_PLACE,
		ST_START,
		ST_UPPER,
		ST_SWEEP,
		ST_WRAP,
		ST_LOWER
	} state_t;

	// side select: upper store holds requests above the head
	localparam logic SIDE_LOWER = 1'b0;
	localparam logic SIDE_UPPER = 1'b1;

endpackage

[src/cscan_disk_scheduler.sv]
// Top level of the C-SCAN disk scheduler.
//
// Usage: requests come in on the req channel (req_valid / req_stall / req),
// one cylinder per transaction; a transaction with batch_end set closes the
// batch. Each request is compared once against start_head: above goes to the
// upper list, below to the lower list, equal is dropped. Both lists together
// hold MAX_REQUESTS entries; extras are dropped and flagged as overflowed.
// Insertion walks the list from the top, one entry shifted per cycle through
// the shared compare unit and the one-write / one-read store RAM. A request
// that is dropped, ignored or lands in an empty list is handled in idle;
// else each larger entry already stored is shifted up before it is placed.
// req_stall is high whenever the block is not idle.
// After the closing transaction the stop order streams out on the stop
// channel, one stop per cycle while stop_stall is low, the first one from
// the start state once the closing request is placed: start, upper list,
// sweep end and wrap (only if the upper list was non-empty), lower list; run_last
// marks the final stop. A batch of n stored requests emits n+1 (or n+3) stops.
// The stop register holds while stop_stall is high and the sequencer waits on it.
// Reset clears the batch counters, flags and registers; store contents are
// never read above the fill counts so need no clearing.
module cscan_disk_scheduler #(
	parameter int unsigned MAX_REQUESTS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  cscan_pkg::req_t     req,
	// stop channel
	output logic                stop_valid,
	input  logic                stop_stall,
	output cscan_pkg::stop_t    stop,
	// APB config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import cscan_pkg::*;

	// index into one list, and counter width able to hold MAX_REQUESTS
	localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam logic [CNT_W:0] CAP = (CNT_W + 1)'(MAX_REQUESTS);

	// ---------------- configuration ----------------
	logic [CYL_W-1:0] start_head_q;
	logic [CYL_W-1:0] max_cyl_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= '0;
			max_cyl_q    <= MAXCYL_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_START_HEAD:   start_head_q <= pwdata[CYL_W-1:0];
				REG_MAX_CYLINDER: max_cyl_q    <= pwdata[CYL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_START_HEAD:   prdata = 32'(start_head_q);
			REG_MAX_CYLINDER: prdata = 32'(max_cyl_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- state ----------------
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  upper_cnt_q, lower_cnt_q;
	logic [RCNT_W-1:0] rcvd_cnt_q;
	logic              ovf_q;
	logic [CYL_W-1:0]  val_q;     // request being inserted
	logic [CNT_W-1:0]  k_q;       // hole position during insertion
	logic              side_q;
	logic              last_q;
	logic [CNT_W-1:0]  idx_q;     // list index during emission
	logic [CYL_W-1:0]  pos_q;     // head position during emission
	logic [SEEK_W-1:0] seek_q;
	stop_t             stop_q;
	logic              stop_valid_q;

	// store interface
	logic [IDX_W:0]    wr_addr, rd_addr;
	logic              wr_en;
	logic [CYL_W-1:0]  wr_data, rd_data;

	// shared unit
	logic [CYL_W-1:0]  op_a, op_b;
	logic              gt;
	logic [SEEK_W-1:0] seek_sum;

	cscan_store #(.IDX_W(IDX_W)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cscan_seek_unit u_seek (
		.a        (op_a),
		.b        (op_b),
		.seek_in  (seek_q),
		.gt       (gt),
		.seek_out (seek_sum)
	);

	// ---------------- decode helpers ----------------
	logic              req_fire;
	logic              slot_free;
	logic              in_equal;
	logic              in_full;
	logic [CNT_W-1:0]  in_cnt;
	logic [CNT_W-1:0]  idx_inc;
	logic [CNT_W-1:0]  k_dec;
	logic [CNT_W-1:0]  k_dec2;
	logic              upper_any, lower_any;
	logic              upper_done, lower_done;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_fire   = req_valid & ~req_stall;
	assign slot_free  = ~stop_valid_q | ~stop_stall;
	assign in_equal   = (req.cylinder == start_head_q);
	assign in_full    = ({1'b0, upper_cnt_q} + {1'b0, lower_cnt_q}) >= CAP;
	assign in_cnt     = gt ? upper_cnt_q : lower_cnt_q;   // gt: cylinder above head in IDLE
	assign idx_inc    = idx_q + 1'b1;
	assign k_dec      = k_q - 1'b1;
	assign k_dec2     = k_q - 2'd2;
	assign upper_any  = (upper_cnt_q != '0);
	assign lower_any  = (lower_cnt_q != '0);
	assign upper_done = (idx_inc == upper_cnt_q);
	assign lower_done = (idx_inc == lower_cnt_q);

	// index of the top entry for a list holding cnt entries
	function automatic logic [IDX_W-1:0] k_dec_in(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] t;
		t = cnt - 1'b1;
		return t[IDX_W-1:0];
	endfunction

	// operand select for the shared unit
	always_comb begin
		unique case (state_q)
			ST_IDLE:   begin op_a = req.cylinder; op_b = start_head_q; end
			ST_INSERT: begin op_a = rd_data;      op_b = val_q;        end
			ST_SWEEP:  begin op_a = pos_q;        op_b = max_cyl_q;    end
			default:   begin op_a = pos_q;        op_b = rd_data;      end
		endcase
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (!in_equal && !in_full && in_cnt != '0) begin
						state_d = ST_INSERT;
					end else if (req.batch_end) begin
						state_d = ST_START;
					end
				end
			end
			ST_INSERT: begin
				if (!gt) begin
					state_d = last_q ? ST_START : ST_IDLE;
				end else if (k_q == CNT_W'(1)) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: state_d = last_q ? ST_START : ST_IDLE;
			ST_START: begin
				if (slot_free) begin
					priority if (upper_any) state_d = ST_UPPER;
					else if (lower_any)     state_d = ST_LOWER;
					else                    state_d = ST_IDLE;
				end
			end
			ST_UPPER: if (slot_free && upper_done) state_d = ST_SWEEP;
			ST_SWEEP: if (slot_free) state_d = ST_WRAP;
			ST_WRAP:  if (slot_free) state_d = lower_any ? ST_LOWER : ST_IDLE;
			ST_LOWER: if (slot_free && lower_done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	logic              emit;
	stop_t             stop_d;
	logic              bump;       // one more entry stored on bump_side
	logic              bump_side;
	logic              clear_batch;
	logic              load_ins;

	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = {side_q, k_q[IDX_W-1:0]};
		wr_data     = val_q;
		rd_addr     = {side_q, k_q[IDX_W-1:0]};
		emit        = 1'b0;
		bump        = 1'b0;
		bump_side   = side_q;
		clear_batch = 1'b0;
		load_ins    = 1'b0;
		stop_d.stop_cylinder = rd_data;
		stop_d.stop_kind     = KIND_REQUEST;
		stop_d.seek_total    = seek_sum;
		stop_d.request_count = rcvd_cnt_q;
		stop_d.overflowed    = ovf_q;
		stop_d.run_last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = {gt, k_dec[IDX_W-1:0]};
				if (req_fire && !in_equal && !in_full) begin
					if (in_cnt == '0) begin
						// empty list: store directly at entry 0
						wr_en     = 1'b1;
						wr_addr   = {gt, {IDX_W{1'b0}}};
						wr_data   = req.cylinder;
						bump      = 1'b1;
						bump_side = gt;
					end else begin
						load_ins = 1'b1;
					end
				end
				// rd_addr: read the current top entry of the chosen list
				if (req_fire && !in_equal && !in_full && in_cnt != '0) begin
					rd_addr = {gt, k_dec_in(in_cnt)};
				end
			end
			ST_INSERT: begin
				wr_en = 1'b1;
				if (gt) begin
					// shift larger entry up one, fetch the next one down
					wr_data = rd_data;
					rd_addr = {side_q, k_dec2[IDX_W-1:0]};
				end else begin
					bump = 1'b1;
				end
			end
			ST_PLACE: begin
				wr_en = 1'b1;
				bump  = 1'b1;
			end
			ST_START: begin
				rd_addr              = {upper_any, {IDX_W{1'b0}}};
				emit                 = slot_free;
				stop_d.stop_cylinder = start_head_q;
				stop_d.stop_kind     = KIND_START;
				stop_d.seek_total    = '0;
				stop_d.run_last      = ~upper_any & ~lower_any;
				clear_batch          = slot_free & ~upper_any & ~lower_any;
			end
			ST_UPPER: begin
				emit = slot_free;
				priority if (!slot_free) rd_addr = {SIDE_UPPER, idx_q[IDX_W-1:0]};
				else if (upper_done)     rd_addr = {SIDE_LOWER, {IDX_W{1'b0}}};
				else                     rd_addr = {SIDE_UPPER, idx_inc[IDX_W-1:0]};
			end
			ST_SWEEP: begin
				rd_addr              = {SIDE_LOWER, {IDX_W{1'b0}}};
				emit                 = slot_free;
				stop_d.stop_cylinder = max_cyl_q;
				stop_d.stop_kind     = KIND_SWEEP;
			end
			ST_WRAP: begin
				rd_addr              = {SIDE_LOWER, {IDX_W{1'b0}}};
				emit                 = slot_free;
				stop_d.stop_cylinder = '0;
				stop_d.stop_kind     = KIND_WRAP;
				stop_d.seek_total    = seek_q;
				stop_d.run_last      = ~lower_any;
				clear_batch          = slot_free & ~lower_any;
			end
			ST_LOWER: begin
				emit            = slot_free;
				stop_d.run_last = lower_done;
				clear_batch     = slot_free & lower_done;
				rd_addr = slot_free ? {SIDE_LOWER, idx_inc[IDX_W-1:0]}
				                    : {SIDE_LOWER, idx_q[IDX_W-1:0]};
			end
			default: ;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// batch counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_cnt_q <= '0;
			lower_cnt_q <= '0;
			rcvd_cnt_q  <= '0;
			ovf_q       <= 1'b0;
		end else if (clear_batch) begin
			upper_cnt_q <= '0;
			lower_cnt_q <= '0;
			rcvd_cnt_q  <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (req_fire) begin
				if (rcvd_cnt_q != RCNT_MAX) begin
					rcvd_cnt_q <= rcvd_cnt_q + 1'b1;
				end
				if (!in_equal && in_full) begin
					ovf_q <= 1'b1;
				end
			end
			if (bump) begin
				if (bump_side == SIDE_UPPER) begin
					upper_cnt_q <= upper_cnt_q + 1'b1;
				end else begin
					lower_cnt_q <= lower_cnt_q + 1'b1;
				end
			end
		end
	end

	// insertion working registers
	always_ff @(posedge clk) begin
		if (load_ins) begin
			val_q  <= req.cylinder;
			k_q    <= in_cnt;
			side_q <= gt;
		end else if (state_q == ST_INSERT && gt) begin
			k_q <= k_dec;
		end
		if (req_fire) begin
			last_q <= req.batch_end;
		end
	end

	// emission working registers
	always_ff @(posedge clk) begin
		if (emit) begin
			unique case (state_q)
				ST_START: begin
					pos_q  <= start_head_q;
					seek_q <= '0;
					idx_q  <= '0;
				end
				ST_UPPER: begin
					pos_q  <= rd_data;
					seek_q <= seek_sum;
					idx_q  <= upper_done ? '0 : idx_inc;
				end
				ST_SWEEP: seek_q <= seek_sum;
				ST_WRAP:  pos_q  <= '0;
				ST_LOWER: begin
					pos_q  <= rd_data;
					seek_q <= seek_sum;
					idx_q  <= idx_inc;
				end
				default: ;
			endcase
		end
	end

	// stop output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_valid_q <= 1'b0;
		end else if (emit) begin
			stop_valid_q <= 1'b1;
		end else if (!stop_stall) begin
			stop_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			stop_q <= stop_d;
		end
	end

	assign stop_valid = stop_valid_q;
	assign stop       = stop_q;

endmodule

[src/cscan_store.sv]
// Request store: upper and lower sorted lists in one single-port-write RAM.
module cscan_store #(
	parameter int unsigned IDX_W = 5
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [IDX_W:0]               wr_addr,
	input  logic [cscan_pkg::CYL_W-1:0]  wr_data,
	input  logic [IDX_W:0]               rd_addr,
	output logic [cscan_pkg::CYL_W-1:0]  rd_data
);
	import cscan_pkg::*;

	localparam int unsigned DEPTH = 2 ** (IDX_W + 1);

	logic [CYL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[src/cscan_seek_unit.sv]
// Shared compare / distance / saturating seek accumulate unit.
module cscan_seek_unit (
	input  logic [cscan_pkg::CYL_W-1:0]  a,
	input  logic [cscan_pkg::CYL_W-1:0]  b,
	input  logic [cscan_pkg::SEEK_W-1:0] seek_in,
	output logic                         gt,
	output logic [cscan_pkg::SEEK_W-1:0] seek_out
);
	import cscan_pkg::*;

	logic [CYL_W-1:0]  travel;
	logic [SEEK_W:0]   sum;

	assign gt   = a > b;
	assign travel = gt ? (a - b) : (b - a);
	assign sum  = {1'b0, seek_in} + (SEEK_W + 1)'(travel);
	assign seek_out = sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];

endmodule
